// ===== rtl/pcfbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfbp_pkg
// Shared widths and codes for the per-channel free block pool.
// ----------------------------------------------------------------------------
package pcfbp_pkg;

   localparam int CHANNELS_DEF   = 8;
   localparam int LIST_DEPTH_DEF = 64;
   localparam int BLOCK_BITS     = 32;

   typedef enum logic [2:0] {
      CMD_INS_FREE = 3'd0,
      CMD_RMV_FREE = 3'd1,
      CMD_QRY_FREE = 3'd2,
      CMD_ALLOC    = 3'd3,
      CMD_RMV_USED = 3'd4,
      CMD_QRY_USED = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_BADLEVEL = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_RR    = 2'd1,
      POL_LEVEL = 2'd2
   } policy_type;

endpackage

// ===== rtl/per_channel_free_block_pool.sv =====
// ----------------------------------------------------------------------------
// per_channel_free_block_pool
// Per-channel FIFO free lists and unordered used lists of block numbers,
// kept in two memories, with insert, remove, query and allocate commands.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | command, block_number, level
//  rsp     | out       | rsp_valid/ready    | out_block, status
//  csr     | in        | csr_valid/ready    | alloc_policy
//
// Insert writes at the tail and goes straight to S_DONE, as does a rejected
// allocate; an allocate reads the head in S_HEAD, moves it in S_MOVE, then the
// free list closes up one entry a cycle. Query and removal scan one entry a
// cycle from the head; removal then closes up the entries behind the match.
// Non power-of-two channel counts add a fold step. Reset clears counts only.
// A stalled response holds the next one in S_DONE; idle still takes requests.
// ----------------------------------------------------------------------------
module per_channel_free_block_pool
   import pcfbp_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_command,
   input  logic [BLOCK_BITS-1:0] req_block_number,
   input  logic signed [7:0]     req_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BLOCK_BITS-1:0] rsp_out_block,
   output logic [1:0]            rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_alloc_policy
);

   localparam int  CW      = $clog2(CHANNELS);
   localparam int  IW      = $clog2(LIST_DEPTH);
   localparam int  NW      = $clog2(LIST_DEPTH + 1);
   localparam int  AW      = $clog2(CHANNELS * LIST_DEPTH);
   localparam int  FW      = $clog2(BLOCK_BITS * CHANNELS);
   localparam int  SH      = FW + CW;
   localparam int  MUL     = ((1 << SH) + CHANNELS - 1) / CHANNELS;
   localparam bit  CH_POW2 = ((CHANNELS & (CHANNELS - 1)) == 0);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CHAN   = 8'b0000_0010,
      S_DECIDE = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_SHIFT  = 8'b0001_0000,
      S_HEAD   = 8'b0010_0000,
      S_MOVE   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] ch,
                                              input logic [IW-1:0] idx);
      addr_of = AW'(ch) * AW'(LIST_DEPTH) + AW'(idx);
   endfunction

   state_type             state_ff, state_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [7:0]            level_ff, level_in;
   logic [CW-1:0]         ch_ff, ch_in;
   logic [FW-1:0]         fold_ff, fold_in;
   logic                  phase_ff, phase_in;
   logic                  sel_used_ff, sel_used_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [NW-1:0]         idx_ff, idx_in;
   logic [NW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  pend_ff, pend_in;
   logic [1:0]            st_ff, st_in;
   logic [BLOCK_BITS-1:0] out_ff, out_in;
   logic [CW-1:0]         last_ff, last_in;
   logic [1:0]            policy_ff, policy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BLOCK_BITS-1:0] rsp_block_ff, rsp_block_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [NW-1:0]         fcnt_ff [CHANNELS];
   logic [NW-1:0]         fcnt_in [CHANNELS];
   logic [NW-1:0]         ucnt_ff [CHANNELS];
   logic [NW-1:0]         ucnt_in [CHANNELS];

   logic                  f_we, f_re, u_we, u_re;
   logic [AW-1:0]         f_wa, f_ra, u_wa, u_ra;
   logic [BLOCK_BITS-1:0] f_wd, u_wd, f_rd, u_rd, mem_rd;

   logic [CHANNELS-1:0]   nonempty;
   logic [CW-1:0]         ch_first, ch_rr, ch_lvl, ch_pick;
   logic                  found_first, found_rr, level_ok, found_pick;
   logic [FW-1:0]         fold_sum, quot, rem_full;
   logic [FW+SH-1:0]      prod;
   int                    j;
   int                    w;

   pcfbp_ram #(.DEPTH(CHANNELS * LIST_DEPTH), .AW(AW)) u_free_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_en(f_re), .rd_addr(f_ra), .rd_data(f_rd)
   );

   pcfbp_ram #(.DEPTH(CHANNELS * LIST_DEPTH), .AW(AW)) u_used_ram (
      .clock(clock), .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_en(u_re), .rd_addr(u_ra), .rd_data(u_rd)
   );

   assign mem_rd = sel_used_ff ? u_rd : f_rd;

   // channel choice for allocate
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         nonempty[c] = (fcnt_ff[c] != '0);
      end
      found_first = 1'b0;
      ch_first    = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
         if (nonempty[c]) begin
            found_first = 1'b1;
            ch_first    = CW'(c);
         end
      end
      found_rr = 1'b0;
      ch_rr    = '0;
      for (int k = CHANNELS - 1; k >= 0; k--) begin
         j = int'(last_ff) + 1 + k;
         if (j >= CHANNELS) begin
            j = j - CHANNELS;
         end
         if (nonempty[j]) begin
            found_rr = 1'b1;
            ch_rr    = CW'(j);
         end
      end
      level_ok = !level_ff[7] && (int'(level_ff[6:0]) < CHANNELS);
      ch_lvl   = CW'(level_ff[6:0]);
      // block mod CHANNELS: fold bit weights, then reciprocal multiply
      fold_sum = '0;
      w        = 1;
      for (int b = 0; b < BLOCK_BITS; b++) begin
         if (blk_ff[b]) begin
            fold_sum = fold_sum + FW'(w);
         end
         w = w * 2;
         if (w >= CHANNELS) begin
            w = w - CHANNELS;
         end
      end
      prod     = (FW + SH)'(fold_ff) * (FW + SH)'(MUL);
      quot     = prod[FW+SH-1:SH];
      rem_full = fold_ff - quot * FW'(CHANNELS);
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      blk_in        = blk_ff;
      level_in      = level_ff;
      ch_in         = ch_ff;
      fold_in       = fold_ff;
      phase_in      = phase_ff;
      sel_used_in   = sel_used_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = pend_ff;
      st_in         = st_ff;
      out_in        = out_ff;
      last_in       = last_ff;
      policy_in     = policy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      fcnt_in       = fcnt_ff;
      ucnt_in       = ucnt_ff;
      f_we = 1'b0; f_wa = '0; f_wd = '0; f_re = 1'b0; f_ra = '0;
      u_we = 1'b0; u_wa = '0; u_wd = '0; u_re = 1'b0; u_ra = '0;
      found_pick = 1'b0;
      ch_pick    = '0;

      if (csr_valid) begin
         policy_in = csr_alloc_policy;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               blk_in   = req_block_number;
               level_in = req_level;
               phase_in = 1'b0;
               out_in   = '0;
               state_in = (req_command == CMD_ALLOC) ? S_DECIDE : S_CHAN;
            end
         end
         S_CHAN: begin
            if (CH_POW2) begin
               ch_in    = blk_ff[CW-1:0];
               state_in = S_DECIDE;
            end else if (!phase_ff) begin
               fold_in  = fold_sum;
               phase_in = 1'b1;
            end else begin
               ch_in    = rem_full[CW-1:0];
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = S_SCAN;
            unique case (cmd_ff)
               CMD_INS_FREE: begin
                  state_in = S_DONE;
                  if (fcnt_ff[ch_ff] >= NW'(LIST_DEPTH)) begin
                     st_in = ST_FULL;
                  end else begin
                     f_we = 1'b1;
                     f_wa = addr_of(ch_ff, fcnt_ff[ch_ff][IW-1:0]);
                     f_wd = blk_ff;
                     fcnt_in[ch_ff] = fcnt_ff[ch_ff] + 1'b1;
                     st_in = ST_OK;
                  end
               end
               CMD_RMV_FREE, CMD_QRY_FREE: begin
                  sel_used_in = 1'b0;
                  cnt_in      = fcnt_ff[ch_ff];
               end
               CMD_RMV_USED, CMD_QRY_USED: begin
                  sel_used_in = 1'b1;
                  cnt_in      = ucnt_ff[ch_ff];
               end
               CMD_ALLOC: begin
                  state_in = S_DONE;
                  st_in    = ST_EMPTY;
                  unique case (policy_ff)
                     POL_FIRST: begin
                        found_pick = found_first;
                        ch_pick    = ch_first;
                     end
                     POL_RR: begin
                        found_pick = found_rr;
                        ch_pick    = ch_rr;
                     end
                     POL_LEVEL: begin
                        ch_pick = ch_lvl;
                        if (level_ok) begin
                           found_pick = nonempty[ch_lvl];
                        end else begin
                           st_in = ST_BADLEVEL;
                        end
                     end
                     default: begin
                        found_pick = 1'b0;
                     end
                  endcase
                  if (found_pick) begin
                     if (ucnt_ff[ch_pick] >= NW'(LIST_DEPTH)) begin
                        st_in = ST_FULL;
                     end else begin
                        ch_in    = ch_pick;
                        state_in = S_HEAD;
                     end
                  end
               end
               default: begin
                  st_in    = ST_EMPTY;
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            pend_in = 1'b0;
            if (pend_ff && (mem_rd == blk_ff)) begin
               if (cmd_ff == CMD_RMV_FREE || cmd_ff == CMD_RMV_USED) begin
                  idx_in   = rd_idx_ff + 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  st_in    = ST_OK;
                  state_in = S_DONE;
               end
            end else if (idx_ff < cnt_ff) begin
               f_re      = !sel_used_ff;
               u_re      = sel_used_ff;
               f_ra      = addr_of(ch_ff, idx_ff[IW-1:0]);
               u_ra      = f_ra;
               pend_in   = 1'b1;
               rd_idx_in = idx_ff;
               idx_in    = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               st_in    = ST_EMPTY;
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            pend_in = 1'b0;
            if (pend_ff) begin
               f_we = !sel_used_ff;
               u_we = sel_used_ff;
               f_wa = addr_of(ch_ff, IW'(rd_idx_ff - 1'b1));
               u_wa = f_wa;
               f_wd = mem_rd;
               u_wd = mem_rd;
            end
            if (idx_ff < cnt_ff) begin
               f_re      = !sel_used_ff;
               u_re      = sel_used_ff;
               f_ra      = addr_of(ch_ff, idx_ff[IW-1:0]);
               u_ra      = f_ra;
               pend_in   = 1'b1;
               rd_idx_in = idx_ff;
               idx_in    = idx_ff + 1'b1;
            end else if (!pend_ff) begin
               if (sel_used_ff) begin
                  ucnt_in[ch_ff] = ucnt_ff[ch_ff] - 1'b1;
               end else begin
                  fcnt_in[ch_ff] = fcnt_ff[ch_ff] - 1'b1;
               end
               st_in    = ST_OK;
               state_in = S_DONE;
            end
         end
         S_HEAD: begin
            f_re        = 1'b1;
            f_ra        = addr_of(ch_ff, '0);
            sel_used_in = 1'b0;
            state_in    = S_MOVE;
         end
         S_MOVE: begin
            u_we           = 1'b1;
            u_wa           = addr_of(ch_ff, ucnt_ff[ch_ff][IW-1:0]);
            u_wd           = f_rd;
            ucnt_in[ch_ff] = ucnt_ff[ch_ff] + 1'b1;
            out_in         = f_rd;
            if (policy_ff == POL_RR) begin
               last_in = ch_ff;
            end
            cnt_in   = fcnt_ff[ch_ff];
            idx_in   = NW'(1);
            pend_in  = 1'b0;
            st_in    = ST_OK;
            state_in = S_SHIFT;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_block_in  = out_ff;
               rsp_status_in = st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= CW'(CHANNELS - 1);
         policy_ff    <= POL_FIRST;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            fcnt_ff[c] <= '0;
            ucnt_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         fcnt_ff      <= fcnt_in;
         ucnt_ff      <= ucnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      blk_ff        <= blk_in;
      level_ff      <= level_in;
      ch_ff         <= ch_in;
      fold_ff       <= fold_in;
      phase_ff      <= phase_in;
      sel_used_ff   <= sel_used_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      st_ff         <= st_in;
      out_ff        <= out_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_block = rsp_block_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/pcfbp_ram.sv =====
// ----------------------------------------------------------------------------
// pcfbp_ram
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module pcfbp_ram
   import pcfbp_pkg::*;
#(
   parameter int DEPTH = CHANNELS_DEF * LIST_DEPTH_DEF,
   parameter int AW    = $clog2(CHANNELS_DEF * LIST_DEPTH_DEF)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [BLOCK_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [BLOCK_BITS-1:0] rd_data
);

   logic [BLOCK_BITS-1:0] mem [DEPTH];
   logic [BLOCK_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pcfbp_checker.sv =====
// ----------------------------------------------------------------------------
// pcfbp_checker
// Port-level checks for the per-channel free block pool.
// ----------------------------------------------------------------------------
module pcfbp_checker
   import pcfbp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [BLOCK_BITS-1:0] rsp_out_block,
   input logic [1:0]            rsp_status
);

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_block)
                                  && $stable(rsp_status))
      else $error("rsp beat changed under stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_out_block == '0)
      else $error("nonzero block on failed beat");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // one request in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind per_channel_free_block_pool pcfbp_checker u_pcfbp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_block(rsp_out_block), .rsp_status(rsp_status)
);

// ===== verif/pool_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_checker
// Watches the request, response and policy channels of the free block pool,
// keeps its own copy of the per-channel free and used lists, predicts the
// response of each accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module pool_checker
   import pcfbp_pkg::*;
#(
   parameter int CHANNELS   = 8,
   parameter int LIST_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [2:0]            req_command,
   input  logic [BLOCK_BITS-1:0] req_block_number,
   input  logic signed [7:0]     req_level,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [BLOCK_BITS-1:0] rsp_out_block,
   input  logic [1:0]            rsp_status,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [1:0]            csr_alloc_policy,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [BLOCK_BITS-1:0] blk;
      logic [1:0]            st;
   } answer_type;

   logic [BLOCK_BITS-1:0] free_list [CHANNELS][$];
   logic [BLOCK_BITS-1:0] used_list [CHANNELS][$];
   int                    last_ch;
   logic [1:0]            policy;
   answer_type            answers [$];

   function automatic int chan_of(logic [BLOCK_BITS-1:0] b);
      return int'(b % CHANNELS);
   endfunction

   function automatic logic [1:0] find_block(bit used, logic [BLOCK_BITS-1:0] b,
                                             bit drop);
      int ch;
      ch = chan_of(b);
      if (used) begin
         foreach (used_list[ch][i]) if (used_list[ch][i] == b) begin
            if (drop) used_list[ch].delete(i);
            return ST_OK;
         end
      end else begin
         foreach (free_list[ch][i]) if (free_list[ch][i] == b) begin
            if (drop) free_list[ch].delete(i);
            return ST_OK;
         end
      end
      return ST_EMPTY;
   endfunction

   function automatic answer_type take_head(int ch);
      answer_type a;
      a.blk = '0;
      if (used_list[ch].size() >= LIST_DEPTH) begin
         a.st = ST_FULL;
         return a;
      end
      a.blk = free_list[ch][0];
      free_list[ch].delete(0);
      used_list[ch].insert(used_list[ch].size(), a.blk);
      a.st = ST_OK;
      return a;
   endfunction

   function automatic answer_type predict_answer(logic [2:0] cmd,
                                                 logic [BLOCK_BITS-1:0] b,
                                                 logic signed [7:0] lvl);
      answer_type a;
      int         ch;
      a.blk = '0;
      a.st  = ST_EMPTY;
      case (cmd)
         CMD_INS_FREE: begin
            ch = chan_of(b);
            if (free_list[ch].size() >= LIST_DEPTH) a.st = ST_FULL;
            else begin
               free_list[ch].insert(free_list[ch].size(), b);
               a.st = ST_OK;
            end
         end
         CMD_RMV_FREE: a.st = find_block(0, b, 1);
         CMD_QRY_FREE: a.st = find_block(0, b, 0);
         CMD_RMV_USED: a.st = find_block(1, b, 1);
         CMD_QRY_USED: a.st = find_block(1, b, 0);
         CMD_ALLOC: begin
            if (policy == POL_FIRST) begin
               for (int c = 0; c < CHANNELS; c++)
                  if (free_list[c].size() != 0) return take_head(c);
            end else if (policy == POL_RR) begin
               ch = (last_ch + 1) % CHANNELS;
               for (int k = 0; k < CHANNELS; k++) begin
                  if (free_list[ch].size() != 0) begin
                     a = take_head(ch);
                     if (a.st == ST_OK) last_ch = ch;
                     return a;
                  end
                  ch = (ch + 1) % CHANNELS;
               end
            end else if (policy == POL_LEVEL) begin
               if (lvl < 0 || lvl >= CHANNELS) a.st = ST_BADLEVEL;
               else if (free_list[int'(lvl)].size() != 0) a = take_head(int'(lvl));
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            free_list[c].delete();
            used_list[c].delete();
         end
         answers.delete();
         last_ch     = CHANNELS - 1;
         policy     <= POL_FIRST;
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (csr_valid && csr_ready) policy <= csr_alloc_policy;
         if (req_valid && req_ready)
            answers.insert(answers.size(),
                           predict_answer(req_command, req_block_number, req_level));
         if (rsp_valid && rsp_ready) begin
            if (answers.size() == 0) begin
               if (fail_count < 10) $display("unexpected response beat at %0t", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = answers[0];
               answers.delete(0);
               if (want.blk !== rsp_out_block || want.st !== rsp_status) begin
                  if (fail_count < 10)
                     $display("mismatch at %0t: block exp %h got %h, status exp %0d got %0d",
                              $realtime, want.blk, rsp_out_block, want.st, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= answers.size();
      end
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the free block pool: directed corner cases, then random
// command streams under every allocation policy with bursty requests and a
// stalling response side. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import pcfbp_pkg::*;

   localparam int CH        = 8;
   localparam int DEPTH     = 64;
   localparam int MAX_CYCLE = 2000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_ready;
   logic [2:0]            req_command = '0;
   logic [BLOCK_BITS-1:0] req_block_number = '0;
   logic signed [7:0]     req_level = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 0;
   logic [BLOCK_BITS-1:0] rsp_out_block;
   logic [1:0]            rsp_status;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [1:0]            csr_alloc_policy = '0;
   int                    fail_count;
   int                    pending;
   int                    cycle = 0;
   int                    hold_off = 0;
   int                    hold_req = 0;
   int                    hold_seen = 0;
   logic [BLOCK_BITS-1:0] recent [$];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   per_channel_free_block_pool #(.CHANNELS(CH), .LIST_DEPTH(DEPTH)) i_dut (.*);

   pool_checker #(.CHANNELS(CH), .LIST_DEPTH(DEPTH)) i_checker (.*);

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: long hold-off on request, otherwise a random stall pattern
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_off  <= 300;
         rsp_ready <= 0;
      end else if (hold_off > 0) begin
         rsp_ready <= 0;
         hold_off  <= hold_off - 1;
      end else begin
         case (cycle / 400 % 3)
            0: rsp_ready <= 1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 1) != 0);
         endcase
      end
   end

   task automatic send(logic [2:0] cmd, logic [BLOCK_BITS-1:0] b, logic signed [7:0] lvl);
      req_valid        <= 1;
      req_command      <= cmd;
      req_block_number <= b;
      req_level        <= lvl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_policy(policy_type p);
      drain();
      csr_valid        <= 1;
      csr_alloc_policy <= p;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [BLOCK_BITS-1:0] pick_block();
      logic [BLOCK_BITS-1:0] b;
      int r;
      r = $urandom_range(0, 9);
      if (r < 5 && recent.size() != 0) b = recent[$urandom_range(0, recent.size() - 1)];
      else if (r < 7) b = $urandom_range(0, 63);
      else b = $urandom;
      return b;
   endfunction

   task automatic random_phase(int n, int ins_weight);
      int sent, burst, r;
      logic [2:0] cmd;
      logic [BLOCK_BITS-1:0] b;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < ins_weight) cmd = CMD_INS_FREE;
            else if (r < ins_weight + 25) cmd = CMD_ALLOC;
            else if (r < 97) cmd = 3'($urandom_range(1, 5));
            else cmd = 3'($urandom_range(6, 7));
            b = pick_block();
            if (cmd == CMD_INS_FREE) begin
               recent.insert(recent.size(), b);
               if (recent.size() > 40) recent.delete(0);
            end
            send(cmd, b, ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty pool, extremes, unused commands, bad levels
      send(CMD_ALLOC, 0, 0);
      send(CMD_QRY_FREE, 32'hFFFF_FFFF, 0);
      send(CMD_INS_FREE, 32'hFFFF_FFFF, 0);
      send(CMD_INS_FREE, 32'h0, 0);
      send(CMD_INS_FREE, 32'h0, 0);
      send(CMD_INS_FREE, 32'h8000_0003, 0);
      send(CMD_QRY_FREE, 32'hFFFF_FFFF, 0);
      send(CMD_RMV_FREE, 32'h0, 0);
      send(CMD_RMV_FREE, 32'h1234_5678, 0);
      send(3'd6, 32'h0, 0);
      send(3'd7, 32'hFFFF_FFFF, -1);
      send(CMD_ALLOC, 0, 0);
      send(CMD_QRY_USED, 32'h0, 0);
      send(CMD_RMV_USED, 32'h0, 0);
      send(CMD_RMV_USED, 32'h0, 0);
      set_policy(POL_LEVEL);
      send(CMD_ALLOC, 0, -128);
      send(CMD_ALLOC, 0, 127);
      send(CMD_ALLOC, 0, 8);
      send(CMD_ALLOC, 0, 7);
      send(CMD_ALLOC, 0, 3);
      send(CMD_ALLOC, 0, 3);
      set_policy(policy_type'(2'd3));
      send(CMD_ALLOC, 0, 0);
      set_policy(POL_RR);
      send(CMD_ALLOC, 0, 0);

      // fill channel 5 free list past full, and its used list too
      for (int k = 0; k <= DEPTH; k++) send(CMD_INS_FREE, 32'(k * 8 + 5), 0);
      set_policy(POL_LEVEL);
      for (int k = 0; k < DEPTH; k++) send(CMD_ALLOC, 0, 5);
      send(CMD_INS_FREE, 32'd13, 0);
      send(CMD_ALLOC, 0, 5);
      set_policy(POL_RR);
      send(CMD_ALLOC, 0, 0);
      set_policy(POL_FIRST);
      send(CMD_ALLOC, 0, 0);

      // long receiver hold-off while requests keep coming
      hold_req <= hold_req + 1;
      random_phase(60, 50);
      drain();

      random_phase(250, 45);
      set_policy(POL_RR);
      random_phase(250, 40);
      set_policy(POL_LEVEL);
      random_phase(250, 40);
      set_policy(POL_FIRST);
      random_phase(200, 35);

      drain();
      if (fail_count == 0 && pending == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/pcfbp_pkg.sv
rtl/pcfbp_ram.sv
rtl/per_channel_free_block_pool.sv
rtl/pcfbp_checker.sv
verif/pool_checker.sv
verif/tb_top.sv
